// ===== sv/dtr_pkg.sv =====
package dtr_pkg;

  // field widths
  localparam int unsigned ActionW   = 2;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned DataW     = 8;
  localparam int unsigned CyclesW   = 8;
  localparam int unsigned DivW      = 16;
  localparam int unsigned PreW      = 11;
  // ceil(255 / 4) = 64 needs seven bits
  localparam int unsigned TickStepW = 7;

  // default step limit of one tick
  localparam int unsigned MaxStepsDef = 64;

  // action codes
  localparam logic [ActionW-1:0] ActRead  = 2'd0;
  localparam logic [ActionW-1:0] ActWrite = 2'd1;
  localparam logic [ActionW-1:0] ActTick  = 2'd2;

  // register index codes
  localparam logic [RegIdxW-1:0] RegDiv    = 2'd0;
  localparam logic [RegIdxW-1:0] RegCount  = 2'd1;
  localparam logic [RegIdxW-1:0] RegReload = 2'd2;
  localparam logic [RegIdxW-1:0] RegCtrl   = 2'd3;

  // reset values and step size
  localparam logic [DivW-1:0]  DivReset  = 16'hAB00;
  localparam logic [DataW-1:0] CtrlReset = 8'hF8;
  localparam logic [DataW-1:0] CountMax  = 8'hFF;
  localparam logic [PreW-1:0]  PreStep   = 11'd4;
  localparam logic [DivW-1:0]  DivStep   = 16'd4;

  // control bit that enables the prescaler
  localparam int unsigned CtrlEnBit = 2;

  // prescale period chosen by the clock select bits
  function automatic logic [PreW-1:0] period_of(input logic [1:0] sel);
    logic [PreW-1:0] p;
    case (sel)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/dtr_if.sv =====
interface dtr_req_if
  import dtr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [RegIdxW-1:0] reg_index;
  logic [DataW-1:0]   write_data;
  logic [CyclesW-1:0] tick_cycles;

  modport source (output valid, action, reg_index, write_data, tick_cycles, input ready);
  modport sink   (input valid, action, reg_index, write_data, tick_cycles, output ready);
endinterface

interface dtr_rsp_if
  import dtr_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             timer_irq;

  modport source (output valid, read_data, timer_irq, input ready);
  modport sink   (input valid, read_data, timer_irq, output ready);
endinterface

// ===== sv/divider_timer_with_reload.sv =====
// channel  dir  payload                                      role
// req_i    in   action, reg_index, write_data, tick_cycles   read, write or tick
// rsp_o    out  read_data, timer_irq                         one result per request
//
// a read or write is answered directly: its result is registered at the transfer edge
// a tick runs its clamped number of steps one per clock, all on
// the separate divider and prescaler adders; the result follows the last step
// (a tick of zero cycles answers at the transfer edge)
// req_i is held off while a tick runs or while an unclaimed result blocks the
// output register; reset loads the register reset values, no clearing pass
module divider_timer_with_reload
  import dtr_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MaxStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtr_req_if.sink   req_i,
  dtr_rsp_if.source rsp_o
);

  localparam int unsigned StepW = $clog2(MAX_STEPS + 1);

  // sequencer state codes
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                state_q, state_d;
  logic [StepW-1:0]    steps_q, steps_d;
  logic                irq_acc_q, irq_acc_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [DataW-1:0]    count_q, count_d;
  logic [DataW-1:0]    reload_q, reload_d;
  logic [DataW-1:0]    ctrl_q, ctrl_d;
  logic [PreW-1:0]     pre_q, pre_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [DataW-1:0]    rsp_data_q, rsp_data_d;
  logic                rsp_irq_q, rsp_irq_d;

  logic                req_xfer;
  logic [DataW-1:0]    rd_byte;
  logic [TickStepW+1:0] cyc_sum;
  logic [TickStepW-1:0] raw_steps;
  logic [StepW-1:0]    tick_steps;
  logic [PreW-1:0]     period;
  logic [PreW-1:0]     pre_sum;
  logic                hit;

  assign req_i.ready = (state_q == StIdle) && (!rsp_valid_q || rsp_o.ready);
  assign req_xfer    = req_i.valid && req_i.ready;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_data = rsp_data_q;
  assign rsp_o.timer_irq = rsp_irq_q;

  // register read mux
  always_comb begin
    case (req_i.reg_index)
      RegDiv:    rd_byte = div_q[DivW-1 -: DataW];
      RegCount:  rd_byte = count_q;
      RegReload: rd_byte = reload_q;
      default:   rd_byte = ctrl_q;
    endcase
  end

  // step count of a tick, clamped
  assign cyc_sum   = {1'b0, req_i.tick_cycles} + (TickStepW + 2)'(3);
  assign raw_steps = cyc_sum[TickStepW+1:2];
  assign tick_steps = (raw_steps > TickStepW'(MAX_STEPS)) ? StepW'(MAX_STEPS)
                                                          : StepW'(raw_steps);

  // shared step unit
  assign period  = period_of(ctrl_q[1:0]);
  assign pre_sum = pre_q + PreStep;
  assign hit     = ctrl_q[CtrlEnBit] && (pre_sum >= period);

  // sequencer and register file
  always_comb begin
    state_d     = state_q;
    steps_d     = steps_q;
    irq_acc_d   = irq_acc_q;
    div_d       = div_q;
    count_d     = count_q;
    reload_d    = reload_q;
    ctrl_d      = ctrl_q;
    pre_d       = pre_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_data_d  = rsp_data_q;
    rsp_irq_d   = rsp_irq_q;

    case (state_q)
      StIdle: begin
        if (req_xfer) begin
          rsp_data_d = '0;
          rsp_irq_d  = 1'b0;
          case (req_i.action)
            ActRead: begin
              rsp_valid_d = 1'b1;
              rsp_data_d  = rd_byte;
            end
            ActWrite: begin
              rsp_valid_d = 1'b1;
              case (req_i.reg_index)
                RegDiv: begin
                  div_d   = '0;
                  count_d = '0;
                end
                RegCount:  count_d  = req_i.write_data;
                RegReload: reload_d = req_i.write_data;
                default: begin
                  if (ctrl_q[1:0] != req_i.write_data[1:0]) begin
                    count_d = '0;
                  end
                  ctrl_d = req_i.write_data;
                end
              endcase
            end
            ActTick: begin
              if (tick_steps == '0) begin
                rsp_valid_d = 1'b1;
              end else begin
                state_d   = StRun;
                steps_d   = tick_steps;
                irq_acc_d = 1'b0;
              end
            end
            default: rsp_valid_d = 1'b1;
          endcase
        end
      end
      StRun: begin
        div_d = div_q + DivStep;
        if (ctrl_q[CtrlEnBit]) begin
          pre_d = pre_sum;
        end
        if (hit) begin
          pre_d = pre_sum & (period - PreW'(1));
          if (count_q == CountMax) begin
            count_d   = reload_q;
            irq_acc_d = 1'b1;
          end else begin
            count_d = count_q + DataW'(1);
          end
        end
        steps_d = steps_q - StepW'(1);
        if (steps_q == StepW'(1)) begin
          state_d     = StIdle;
          rsp_valid_d = 1'b1;
          rsp_data_d  = '0;
          rsp_irq_d   = irq_acc_d;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control and timer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      steps_q     <= '0;
      irq_acc_q   <= 1'b0;
      div_q       <= DivReset;
      count_q     <= '0;
      reload_q    <= '0;
      ctrl_q      <= CtrlReset;
      pre_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      irq_acc_q   <= irq_acc_d;
      div_q       <= div_d;
      count_q     <= count_d;
      reload_q    <= reload_d;
      ctrl_q      <= ctrl_d;
      pre_q       <= pre_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
    rsp_irq_q  <= rsp_irq_d;
  end

  // a running tick always has steps left
  a_run_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (steps_q != '0))
    else $error("tick running with no steps left");

  // a divider read returns the upper byte seen at the transfer
  a_div_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && req_i.action == ActRead && req_i.reg_index == RegDiv) |=>
      (rsp_o.valid && rsp_o.read_data == $past(div_q[DivW-1 -: DataW])))
    else $error("divider read mismatch");

  // an interrupt needs the prescaler enabled
  a_irq_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.timer_irq) |-> ctrl_q[CtrlEnBit])
    else $error("interrupt with prescaler disabled");

  // no request taken while a tick runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> !req_i.ready)
    else $error("request taken during tick");

endmodule
